### rtl/vfg_pkg.sv
// ----------------------------------------------------------------------------
// vfg_pkg
// shared types and constants for the view follow glide block
// ----------------------------------------------------------------------------
package vfg_pkg;

   // command codes carried in req_tuser
   localparam logic [1:0] CMD_WALK_START = 2'd0;
   localparam logic [1:0] CMD_TICK       = 2'd1;
   localparam logic [1:0] CMD_CANCEL     = 2'd2;
   localparam logic [1:0] CMD_REFUSED    = 2'd3;

   // configuration register indexes
   localparam logic [1:0] REG_FOLLOW_ENABLE = 2'd0;
   localparam logic [1:0] REG_VIEW_WIDTH    = 2'd1;
   localparam logic [1:0] REG_VIEW_HEIGHT   = 2'd2;

   localparam int VIEW_W        = 13;
   localparam int REQ_DATA_W    = 72;
   localparam int RSP_DATA_W    = 40;
   localparam int STEP_W        = 17;
   localparam int OFS_W         = 17;

   // art origin to centre of tile
   localparam logic signed [OFS_W-1:0] POINT_OFS_X = 17'sd16;
   localparam logic signed [OFS_W-1:0] POINT_OFS_Y = 17'sd8;

   localparam logic [VIEW_W-1:0] RESET_WIDTH  = 13'd640;
   localparam logic [VIEW_W-1:0] RESET_HEIGHT = 13'd380;

   // one request word, highest field first
   typedef struct packed {
      logic [3:0]         pad;
      logic [31:0]        now_ms;
      logic               world_frozen;
      logic               walk_busy;
      logic               walker_is_point;
      logic               point_present;
      logic signed [15:0] point_y;
      logic signed [15:0] point_x;
   } req_item_type;

   // one response word, highest field first
   typedef struct packed {
      logic [3:0]              pad;
      logic                    follow_active;
      logic signed [STEP_W-1:0] step_y;
      logic signed [STEP_W-1:0] step_x;
      logic                    scroll_request;
   } rsp_item_type;

endpackage

### rtl/view_follow_glide.sv
// ----------------------------------------------------------------------------
// view_follow_glide
// exponential glide of the view towards a tracked point, one word per event
// ----------------------------------------------------------------------------
// path: an accepted request word is held in the input register, and the result
//   register loads from it once the result slot is free
// throughput: one word per cycle unless rsp_tready stalls; the gain rom read,
//   two multiplies and the carry adds sit in a single stage between the registers
// reset (synchronous): follow disarmed, time stamp and carries cleared,
//   enable 1, width 640, height 380; no clearing pass
// ----------------------------------------------------------------------------
module view_follow_glide #(
   parameter int TAU_MS      = 160,
   parameter int DT_LIMIT_MS = 100,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // tdata: point_x, point_y, point_present, walker_is_point, walk_busy,
   //        world_frozen, now_ms, zero pad
   input  logic [vfg_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: command
   input  logic [1:0]                    req_tuser,
   // response channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // tdata: scroll_request, step_x, step_y, follow_active, zero pad
   output logic [vfg_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // register write port
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [vfg_pkg::VIEW_W-1:0]    csr_wdata
);

   // ------------------------------------------------------------------------
   // gain rom: k[dt] = round(2^FRAC_BITS * (1 - exp(-dt/TAU_MS))), built at
   // elaboration with 60 fractional bits
   // ------------------------------------------------------------------------
   localparam int K_W   = FRAC_BITS + 1;          // k may round up to one
   localparam int DT_W  = $clog2(DT_LIMIT_MS + 1);
   localparam int CAR_W = FRAC_BITS + 1;          // signed, below one pixel
   localparam int PRD_W = vfg_pkg::OFS_W + K_W + 1;
   localparam int SUM_W = PRD_W + 1;

   typedef logic [K_W-1:0] rom_type [0:DT_LIMIT_MS];

   function automatic logic [63:0] mul60(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[123:60];
   endfunction

   function automatic rom_type glide_rom_build();
      rom_type     rom;
      logic [63:0] one60;
      logic [63:0] y;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] r;
      logic [63:0] p;
      logic [63:0] k;
      logic [63:0] rk;
      one60 = 64'd1 << 60;
      y     = one60 / 64'(TAU_MS);
      term  = one60;
      pos   = one60;
      neg   = 64'd0;
      for (int n = 1; n <= 40; n++) begin
         term = mul60(term, y) / 64'(n);
         if ((n % 2) == 1) begin
            neg = neg + term;
         end else begin
            pos = pos + term;
         end
      end
      r      = pos - neg;
      p      = one60;
      rom[0] = '0;
      for (int dt = 1; dt <= DT_LIMIT_MS; dt++) begin
         p       = mul60(p, r);
         k       = one60 - p;
         rk      = (k + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
         rom[dt] = rk[K_W-1:0];
      end
      return rom;
   endfunction

   localparam rom_type GLIDE_ROM = glide_rom_build();

   // ------------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------------
   logic                      follow_enable_ff;
   logic [vfg_pkg::VIEW_W-1:0] view_width_ff;
   logic [vfg_pkg::VIEW_W-1:0] view_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         follow_enable_ff <= 1'b1;
         view_width_ff    <= vfg_pkg::RESET_WIDTH;
         view_height_ff   <= vfg_pkg::RESET_HEIGHT;
      end else if (csr_we) begin
         case (csr_index)
            vfg_pkg::REG_FOLLOW_ENABLE: follow_enable_ff <= csr_wdata[0];
            vfg_pkg::REG_VIEW_WIDTH:    view_width_ff    <= csr_wdata;
            vfg_pkg::REG_VIEW_HEIGHT:   view_height_ff   <= csr_wdata;
            default: ;                  // unused index, write dropped
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // handshake: the input feeds the result register; if full, both move together
   // ------------------------------------------------------------------------
   logic                  in_valid_ff;
   vfg_pkg::req_item_type in_item_ff;
   logic [1:0]            in_cmd_ff;
   logic                  rsp_valid_ff;
   vfg_pkg::rsp_item_type rsp_item_ff;
   logic                  advance;
   logic                  load;

   assign advance    = !rsp_valid_ff || rsp_tready;  // result slot free next edge
   assign load       = in_valid_ff && advance;       // word processed this cycle
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff <= vfg_pkg::req_item_type'(req_tdata);
         in_cmd_ff  <= req_tuser;
      end
   end

   // ------------------------------------------------------------------------
   // follow state
   // ------------------------------------------------------------------------
   logic                    armed_ff, armed_in;
   logic [31:0]             last_time_ff, last_time_in;
   logic signed [CAR_W-1:0] carry_x_ff, carry_x_in;
   logic signed [CAR_W-1:0] carry_y_ff, carry_y_in;

   // offsets of the point from the view centre
   logic signed [vfg_pkg::OFS_W-1:0] dx, dy;
   logic [vfg_pkg::OFS_W-1:0]        abs_dx, abs_dy;
   logic                             in_zone, in_deadband;

   assign dx = vfg_pkg::OFS_W'(in_item_ff.point_x) + vfg_pkg::POINT_OFS_X
             - $signed({5'd0, view_width_ff[vfg_pkg::VIEW_W-1:1]});
   assign dy = vfg_pkg::OFS_W'(in_item_ff.point_y) + vfg_pkg::POINT_OFS_Y
             - $signed({5'd0, view_height_ff[vfg_pkg::VIEW_W-1:1]});
   assign abs_dx = dx[vfg_pkg::OFS_W-1] ? 17'(-dx) : 17'(dx);
   assign abs_dy = dy[vfg_pkg::OFS_W-1] ? 17'(-dy) : 17'(dy);

   // arming zone is half the half-size on each axis
   assign in_zone = (abs_dx <= {6'd0, view_width_ff[vfg_pkg::VIEW_W-1:2]})
                 && (abs_dy <= {6'd0, view_height_ff[vfg_pkg::VIEW_W-1:2]});
   assign in_deadband = (abs_dx <= 17'd1) && (abs_dy <= 17'd1);

   // elapsed time, clamped to the rom depth
   logic [31:0]             dt_raw;
   logic [DT_W-1:0]         dt_idx;
   logic [K_W-1:0]          gain;
   logic signed [K_W:0]     gain_s;

   assign dt_raw = in_item_ff.now_ms - last_time_ff;
   assign dt_idx = (dt_raw > 32'(DT_LIMIT_MS)) ? DT_W'(DT_LIMIT_MS) : dt_raw[DT_W-1:0];
   assign gain   = GLIDE_ROM[dt_idx];
   assign gain_s = $signed({1'b0, gain});

   // carry update: s = carry + d*k, step = s truncated toward zero
   logic signed [PRD_W-1:0] prod_x, prod_y;
   logic signed [SUM_W-1:0] sum_x, sum_y;
   logic signed [SUM_W-1:0] flr_x, flr_y;
   logic signed [SUM_W-1:0] trn_x, trn_y;
   logic                    frac_x_nz, frac_y_nz;
   logic                    neg_x_adj, neg_y_adj;

   assign prod_x = dx * gain_s;
   assign prod_y = dy * gain_s;
   assign sum_x  = SUM_W'(carry_x_ff) + SUM_W'(prod_x);
   assign sum_y  = SUM_W'(carry_y_ff) + SUM_W'(prod_y);
   assign flr_x  = sum_x >>> FRAC_BITS;
   assign flr_y  = sum_y >>> FRAC_BITS;
   assign frac_x_nz = |sum_x[FRAC_BITS-1:0];
   assign frac_y_nz = |sum_y[FRAC_BITS-1:0];
   // negative sums with a fraction round the floor back up toward zero
   assign neg_x_adj = sum_x[SUM_W-1] && frac_x_nz;
   assign neg_y_adj = sum_y[SUM_W-1] && frac_y_nz;
   assign trn_x  = neg_x_adj ? flr_x + SUM_W'(1) : flr_x;
   assign trn_y  = neg_y_adj ? flr_y + SUM_W'(1) : flr_y;

   logic                               req_out;
   logic signed [vfg_pkg::STEP_W-1:0]  step_x_out, step_y_out;
   logic signed [vfg_pkg::STEP_W-1:0]  step_x_calc, step_y_calc;

   // remainder keeps the sign of the sum, so it is just the low bits with sign
   assign step_x_calc = trn_x[vfg_pkg::STEP_W-1:0];
   assign step_y_calc = trn_y[vfg_pkg::STEP_W-1:0];

   always_comb begin
      armed_in     = armed_ff;
      last_time_in = last_time_ff;
      carry_x_in   = carry_x_ff;
      carry_y_in   = carry_y_ff;
      req_out      = 1'b0;
      step_x_out   = '0;
      step_y_out   = '0;
      if (load) begin
         case (in_cmd_ff)
            vfg_pkg::CMD_WALK_START: begin
               if (in_item_ff.walker_is_point && follow_enable_ff
                   && in_item_ff.point_present) begin
                  armed_in     = in_zone;
                  last_time_in = in_item_ff.now_ms;
                  carry_x_in   = '0;
                  carry_y_in   = '0;
               end
            end
            vfg_pkg::CMD_TICK: begin
               if (armed_ff) begin
                  if (!follow_enable_ff || !in_item_ff.point_present
                      || !in_item_ff.walk_busy) begin
                     armed_in = 1'b0;
                  end else if (in_item_ff.world_frozen) begin
                     last_time_in = in_item_ff.now_ms;
                  end else begin
                     last_time_in = in_item_ff.now_ms;
                     if ((dt_raw != 32'd0) && !in_deadband) begin
                        carry_x_in = {neg_x_adj, sum_x[FRAC_BITS-1:0]};
                        carry_y_in = {neg_y_adj, sum_y[FRAC_BITS-1:0]};
                        req_out    = (step_x_calc != '0) || (step_y_calc != '0);
                        step_x_out = step_x_calc;
                        step_y_out = step_y_calc;
                     end
                  end
               end
            end
            vfg_pkg::CMD_CANCEL:  armed_in = 1'b0;
            vfg_pkg::CMD_REFUSED: armed_in = 1'b0;
            default:              armed_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff     <= 1'b0;
         last_time_ff <= '0;
         carry_x_ff   <= '0;
         carry_y_ff   <= '0;
      end else begin
         armed_ff     <= armed_in;
         last_time_ff <= last_time_in;
         carry_x_ff   <= carry_x_in;
         carry_y_ff   <= carry_y_in;
      end
   end

   // ------------------------------------------------------------------------
   // result register
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_item_ff.pad            <= '0;
         rsp_item_ff.scroll_request <= req_out;
         rsp_item_ff.step_x         <= step_x_out;
         rsp_item_ff.step_y         <= step_y_out;
         rsp_item_ff.follow_active  <= armed_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_item_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_cancel_disarms: assert property (@(posedge clock) disable iff (reset)
      load && (in_cmd_ff == vfg_pkg::CMD_CANCEL || in_cmd_ff == vfg_pkg::CMD_REFUSED)
      |=> !armed_ff)
      else $error("cancel or refused scroll left the follow armed");

   a_active_matches_state: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_item_ff.follow_active == armed_ff)
      else $error("follow_active disagrees with armed state");

   a_no_request_no_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_item_ff.scroll_request
      |-> rsp_item_ff.step_x == '0 && rsp_item_ff.step_y == '0)
      else $error("step emitted without a scroll request");

   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      !load |=> $stable(armed_ff) && $stable(carry_x_ff) && $stable(carry_y_ff)
                && $stable(last_time_ff))
      else $error("follow state changed with no word processed");

   a_disarmed_no_step: assert property (@(posedge clock) disable iff (reset)
      load && !armed_ff && in_cmd_ff == vfg_pkg::CMD_TICK
      |=> !rsp_item_ff.scroll_request && $stable(carry_x_ff))
      else $error("tick while disarmed produced a step");

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for view_follow_glide: a table of directed words, then
// random walk and tick sequences under several register settings and idling
// patterns; every response word is checked against a local glide predictor
// or, for table rows that carry one, against a hand-typed answer
module tb_top;

   localparam int TAU_MS         = 160;
   localparam int DT_LIMIT_MS    = 100;
   localparam int FRAC_BITS      = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_WORDS    = 160;
   localparam int PLAN_ROWS      = 26;

   localparam logic [63:0] ONE60     = 64'h1000_0000_0000_0000;
   localparam longint      GLIDE_ONE = longint'(1) << FRAC_BITS;

   // ports of the block, the inputs driven known from time zero
   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [vfg_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic [1:0]                     req_tuser  = vfg_pkg::CMD_TICK;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [vfg_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_we     = 1'b0;
   logic [1:0]                     csr_index  = vfg_pkg::REG_FOLLOW_ENABLE;
   logic [vfg_pkg::VIEW_W-1:0]     csr_wdata  = '0;

   view_follow_glide #(
      .TAU_MS      (TAU_MS),
      .DT_LIMIT_MS (DT_LIMIT_MS),
      .FRAC_BITS   (FRAC_BITS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 10 unit period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // predictor state: registers as the block should hold them
   // ------------------------------------------------------------------------
   logic                       cfg_enable = 1'b1;
   logic [vfg_pkg::VIEW_W-1:0] cfg_width  = vfg_pkg::RESET_WIDTH;
   logic [vfg_pkg::VIEW_W-1:0] cfg_height = vfg_pkg::RESET_HEIGHT;

   logic        follow_armed = 1'b0;
   logic [31:0] stamp_ms     = '0;
   longint      frac_x       = 0;
   longint      frac_y       = 0;

   // gain table, 1 - exp(-dt/tau) in q0.16
   logic [31:0] gain_rom [0:DT_LIMIT_MS];

   vfg_pkg::rsp_item_type pending_steps [$];

   int failures       = 0;
   int words_sent     = 0;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int stall_cycles   = 0;
   logic [31:0] clock_ms = '0;

   // (a*b) >> 60 on q60 values, truncated
   function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[123:60];
   endfunction

   function automatic int mag(input int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic int rand_span(input int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   // series for exp(-1/tau) in q60, then powers of it for each dt
   initial begin : build_gain_rom
      logic [63:0] y, term, pos, neg, r, p, k;
      int n, dt;
      y    = ONE60 / TAU_MS;
      term = ONE60;
      pos  = ONE60;
      neg  = '0;
      for (n = 1; n <= 40; n++) begin
         term = q60_mul(term, y) / 64'(n);
         if (n % 2 == 1) neg += term;
         else pos += term;
      end
      r = pos - neg;
      p = ONE60;
      gain_rom[0] = '0;
      for (dt = 1; dt <= DT_LIMIT_MS; dt++) begin
         p = q60_mul(p, r);
         k = ONE60 - p;
         gain_rom[dt] = 32'((k + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS));
      end
   end

   // works out the response to one accepted word and advances the state
   task automatic glide_step(input vfg_pkg::req_item_type w, input logic [1:0] cmd,
                             output vfg_pkg::rsp_item_type r);
      int dx, dy, zx, zy;
      logic [31:0] dt;
      longint s, sx, sy, k;
      r  = '0;
      sx = 0;
      sy = 0;
      // offset of the tile centre from the view centre
      dx = int'($signed(w.point_x)) + 16 - int'(cfg_width / 2);
      dy = int'($signed(w.point_y)) + 8 - int'(cfg_height / 2);
      case (cmd)
         vfg_pkg::CMD_WALK_START: begin
            if (w.walker_is_point && cfg_enable && w.point_present) begin
               zx = int'((cfg_width / 2) / 2);
               zy = int'((cfg_height / 2) / 2);
               follow_armed = (mag(dx) <= zx) && (mag(dy) <= zy);
               stamp_ms = w.now_ms;
               frac_x = 0;
               frac_y = 0;
            end
         end
         vfg_pkg::CMD_TICK: begin
            if (follow_armed) begin
               if (!cfg_enable || !w.point_present || !w.walk_busy) begin
                  follow_armed = 1'b0;
               end else if (w.world_frozen) begin
                  stamp_ms = w.now_ms;
               end else begin
                  dt = w.now_ms - stamp_ms;
                  stamp_ms = w.now_ms;
                  // no time passed, or inside the one pixel deadband
                  if (dt != 0 && !(mag(dx) <= 1 && mag(dy) <= 1)) begin
                     if (dt > DT_LIMIT_MS) dt = DT_LIMIT_MS;
                     k  = longint'(gain_rom[dt]);
                     s  = frac_x + longint'(dx) * k;
                     sx = s / GLIDE_ONE;
                     frac_x = s - sx * GLIDE_ONE;
                     s  = frac_y + longint'(dy) * k;
                     sy = s / GLIDE_ONE;
                     frac_y = s - sy * GLIDE_ONE;
                     r.scroll_request = (sx != 0) || (sy != 0);
                  end
               end
            end
         end
         default: begin
            // cancel or refused scroll
            follow_armed = 1'b0;
         end
      endcase
      r.step_x        = sx[vfg_pkg::STEP_W-1:0];
      r.step_y        = sy[vfg_pkg::STEP_W-1:0];
      r.follow_active = follow_armed;
   endtask

   // ------------------------------------------------------------------------
   // request side: called at a falling edge, returns at a falling edge
   // ------------------------------------------------------------------------
   task automatic push_word(input vfg_pkg::req_item_type w, input logic [1:0] cmd,
                            input logic typed, input vfg_pkg::rsp_item_type typed_rsp);
      vfg_pkg::rsp_item_type predicted;
      while (int'($urandom_range(0, 99)) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      glide_step(w, cmd, predicted);
      // rows with a hand-typed answer are held to it
      pending_steps.push_back(typed ? typed_rsp : predicted);
      words_sent++;
      @(negedge clock);
   endtask

   // lower valid and let the pipe run dry
   task automatic drain_pipe;
      req_tvalid <= 1'b0;
      while (pending_steps.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // block is idle here, one register per falling edge
   task automatic apply_config(input logic en, input logic [vfg_pkg::VIEW_W-1:0] wd,
                               input logic [vfg_pkg::VIEW_W-1:0] ht);
      csr_we    <= 1'b1;
      csr_index <= vfg_pkg::REG_FOLLOW_ENABLE;
      csr_wdata <= {{(vfg_pkg::VIEW_W-1){1'b0}}, en};
      @(negedge clock);
      csr_index <= vfg_pkg::REG_VIEW_WIDTH;
      csr_wdata <= wd;
      @(negedge clock);
      csr_index <= vfg_pkg::REG_VIEW_HEIGHT;
      csr_wdata <= ht;
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_enable = en;
      cfg_width  = wd;
      cfg_height = ht;
   endtask

   // mostly walk start then a run of ticks near the centre, with some noise
   task automatic run_phase(input int words);
      int target, half_w, half_h, zx, zy, span_x, span_y, pick;
      vfg_pkg::req_item_type w;
      target = words_sent + words;
      half_w = int'(cfg_width / 2);
      half_h = int'(cfg_height / 2);
      zx     = half_w / 2;
      zy     = half_h / 2;
      while (words_sent < target) begin
         if ($urandom_range(0, 3) == 0) begin
            // noise: every field random
            w = '0;
            w.point_x         = 16'($urandom);
            w.point_y         = 16'($urandom);
            w.point_present   = 1'($urandom);
            w.walker_is_point = 1'($urandom);
            w.walk_busy       = 1'($urandom);
            w.world_frozen    = 1'($urandom);
            w.now_ms          = $urandom;
            push_word(w, 2'($urandom_range(0, 3)), 1'b0, '0);
         end else begin
            // walk start, mostly inside the arming zone
            span_x = ($urandom_range(0, 6) == 0) ? zx * 2 + 2 : zx;
            span_y = ($urandom_range(0, 6) == 0) ? zy * 2 + 2 : zy;
            clock_ms += $urandom_range(0, 2000);
            w = '0;
            w.point_x         = 16'(half_w - 16 + rand_span(span_x));
            w.point_y         = 16'(half_h - 8 + rand_span(span_y));
            w.point_present   = ($urandom_range(0, 9) != 0);
            w.walker_is_point = ($urandom_range(0, 9) != 0);
            w.walk_busy       = 1'($urandom);
            w.world_frozen    = 1'($urandom);
            w.now_ms          = clock_ms;
            push_word(w, vfg_pkg::CMD_WALK_START, 1'b0, '0);
            repeat ($urandom_range(3, 30)) begin
               pick = $urandom_range(0, 99);
               if (pick < 5) clock_ms += 0;
               else if (pick < 10) clock_ms += $urandom;
               else clock_ms += $urandom_range(1, 120);
               if ($urandom_range(0, 6) == 0) begin
                  // close to the centre, deadband edge
                  span_x = 2;
                  span_y = 2;
               end else begin
                  span_x = (zx * 2 > 4) ? zx * 2 : 4;
                  span_y = (zy * 2 > 4) ? zy * 2 : 4;
               end
               w = '0;
               w.point_x         = 16'(half_w - 16 + rand_span(span_x));
               w.point_y         = 16'(half_h - 8 + rand_span(span_y));
               w.point_present   = ($urandom_range(0, 49) != 0);
               w.walker_is_point = 1'($urandom);
               w.walk_busy       = ($urandom_range(0, 39) != 0);
               w.world_frozen    = ($urandom_range(0, 9) == 0);
               w.now_ms          = clock_ms;
               push_word(w, vfg_pkg::CMD_TICK, 1'b0, '0);
            end
            // how the walk ends
            pick = $urandom_range(0, 99);
            w.walk_busy = 1'b0;
            w.now_ms    = clock_ms;
            if (pick < 40) push_word(w, vfg_pkg::CMD_TICK, 1'b0, '0);
            else if (pick < 60) push_word(w, vfg_pkg::CMD_CANCEL, 1'b0, '0);
            else if (pick < 80) push_word(w, vfg_pkg::CMD_REFUSED, 1'b0, '0);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // directed table, under the reset settings (640 x 380, zone 160 x 95)
   // point (304, 182) sits exactly on the view centre
   // ------------------------------------------------------------------------
   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic               present;
      logic               is_point;
      logic               busy;
      logic               frozen;
      logic [31:0]        now;
      logic               typed;
      logic               e_req;
      logic signed [16:0] e_sx;
      logic signed [16:0] e_sy;
      logic               e_act;
   } plan_row_type;

   plan_row_type plan [PLAN_ROWS] = '{
      // tick straight after reset, nothing armed
      '{vfg_pkg::CMD_TICK, 304, 182, 1, 1, 1, 0, 32'd0, 1, 0, 0, 0, 0},
      '{vfg_pkg::CMD_CANCEL, 0, 0, 0, 0, 0, 0, 32'd0, 1, 0, 0, 0, 0},
      // walk start by someone else, then with the point missing
      '{vfg_pkg::CMD_WALK_START, 304, 182, 1, 0, 1, 0, 32'd500, 1, 0, 0, 0, 0},
      '{vfg_pkg::CMD_WALK_START, 304, 182, 0, 1, 1, 0, 32'd500, 1, 0, 0, 0, 0},
      // extreme corners, far outside the zone
      '{vfg_pkg::CMD_WALK_START, 32767, 32767, 1, 1, 1, 0, 32'd600, 1, 0, 0, 0, 0},
      '{vfg_pkg::CMD_WALK_START, -32768, -32768, 1, 1, 1, 0, 32'd600, 1, 0, 0, 0, 0},
      '{vfg_pkg::CMD_WALK_START, 304, 182, 1, 1, 1, 0, 32'd1000, 1, 0, 0, 0, 1},
      // no time passed
      '{vfg_pkg::CMD_TICK, 404, 182, 1, 1, 1, 0, 32'd1000, 1, 0, 0, 0, 1},
      // deadband
      '{vfg_pkg::CMD_TICK, 305, 181, 1, 1, 1, 0, 32'd1010, 1, 0, 0, 0, 1},
      // frozen world only re-stamps
      '{vfg_pkg::CMD_TICK, 404, 282, 1, 1, 1, 1, 32'd1050, 1, 0, 0, 0, 1},
      '{vfg_pkg::CMD_TICK, 404, 282, 1, 1, 1, 0, 32'd1066, 0, 0, 0, 0, 0},
      // long gap with the point at the far corner
      '{vfg_pkg::CMD_TICK, 32767, -32768, 1, 1, 1, 0, 32'd900000, 0, 0, 0, 0, 0},
      // small offset, step rounds to zero
      '{vfg_pkg::CMD_TICK, 306, 182, 1, 1, 1, 0, 32'd900001, 0, 0, 0, 0, 0},
      // walk start by someone else leaves the follow armed
      '{vfg_pkg::CMD_WALK_START, 304, 182, 1, 0, 1, 0, 32'd900002, 1, 0, 0, 0, 1},
      // walk over
      '{vfg_pkg::CMD_TICK, 350, 150, 1, 1, 0, 0, 32'd900010, 1, 0, 0, 0, 0},
      // one pixel outside the zone, then on its edge
      '{vfg_pkg::CMD_WALK_START, 465, 182, 1, 1, 1, 0, 32'd1000000, 1, 0, 0, 0, 0},
      '{vfg_pkg::CMD_WALK_START, 464, 87, 1, 1, 1, 0, 32'hFFFF_FFF0, 1, 0, 0, 0, 1},
      // time stamp wraps
      '{vfg_pkg::CMD_TICK, -32768, 32767, 1, 1, 1, 0, 32'd5, 0, 0, 0, 0, 0},
      '{vfg_pkg::CMD_TICK, 464, 87, 1, 1, 1, 0, 32'd16, 0, 0, 0, 0, 0},
      '{vfg_pkg::CMD_REFUSED, 464, 87, 1, 1, 1, 0, 32'd20, 1, 0, 0, 0, 0},
      // opposite zone edge at the top of the time range
      '{vfg_pkg::CMD_WALK_START, 144, 277, 1, 1, 1, 0, 32'hFFFF_FFFF, 1, 0, 0, 0, 1},
      // point lost
      '{vfg_pkg::CMD_TICK, 304, 182, 0, 1, 1, 0, 32'd40, 1, 0, 0, 0, 0},
      '{vfg_pkg::CMD_WALK_START, 304, 182, 1, 1, 1, 0, 32'd50, 1, 0, 0, 0, 1},
      '{vfg_pkg::CMD_CANCEL, 304, 182, 1, 1, 1, 0, 32'd60, 1, 0, 0, 0, 0},
      '{vfg_pkg::CMD_TICK, 400, 300, 1, 1, 1, 0, 32'd70, 1, 0, 0, 0, 0},
      '{vfg_pkg::CMD_REFUSED, 400, 300, 1, 1, 1, 0, 32'd80, 1, 0, 0, 0, 0}
   };

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int i, ph;
      vfg_pkg::req_item_type w;
      vfg_pkg::rsp_item_type typed_rsp;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows, reset register values
      for (i = 0; i < PLAN_ROWS; i++) begin
         w = '0;
         w.point_x         = plan[i].px;
         w.point_y         = plan[i].py;
         w.point_present   = plan[i].present;
         w.walker_is_point = plan[i].is_point;
         w.walk_busy       = plan[i].busy;
         w.world_frozen    = plan[i].frozen;
         w.now_ms          = plan[i].now;
         typed_rsp = '0;
         typed_rsp.scroll_request = plan[i].e_req;
         typed_rsp.step_x         = plan[i].e_sx;
         typed_rsp.step_y         = plan[i].e_sy;
         typed_rsp.follow_active  = plan[i].e_act;
         push_word(w, plan[i].cmd, plan[i].typed, typed_rsp);
      end
      drain_pipe();

      // random phases: each setting with one of the idling patterns
      for (ph = 0; ph < 8; ph++) begin
         case (ph)
            0: apply_config(1'b1, 13'd640, 13'd380);
            1: apply_config(1'b1, 13'd8191, 13'd8191);
            2: apply_config(1'b1, 13'd0, 13'd0);
            3: apply_config(1'b0, 13'd640, 13'd380);
            4: apply_config(1'b1, 13'd1, 13'd8191);
            5: apply_config(1'b1, 13'($urandom), 13'($urandom));
            6: apply_config(1'b1, 13'd8191, 13'd0);
            default: apply_config(1'b1, 13'd640, 13'd380);
         endcase
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            1: begin send_idle_pct = 47; recv_idle_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_idle_pct = 47; end
            default: begin send_idle_pct = 25; recv_idle_pct = 25; end
         endcase
         run_phase(PHASE_WORDS);
         drain_pipe();
      end

      // last words have had time to come out
      repeat (8) @(posedge clock);
      if (failures == 0 && pending_steps.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // response side: random back-pressure, field by field check
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_tready <= (int'($urandom_range(0, 99)) >= recv_idle_pct);
   end

   vfg_pkg::rsp_item_type got_word;
   vfg_pkg::rsp_item_type want_word;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_word = rsp_tdata;
         if (pending_steps.size() == 0) begin
            $error("response word with no expectation waiting");
            failures++;
         end else begin
            want_word = pending_steps.pop_front();
            if (got_word.scroll_request !== want_word.scroll_request) begin
               $error("scroll_request: expected %0d, got %0d",
                      want_word.scroll_request, got_word.scroll_request);
               failures++;
            end
            if (got_word.step_x !== want_word.step_x) begin
               $error("step_x: expected %0d, got %0d", want_word.step_x, got_word.step_x);
               failures++;
            end
            if (got_word.step_y !== want_word.step_y) begin
               $error("step_y: expected %0d, got %0d", want_word.step_y, got_word.step_y);
               failures++;
            end
            if (got_word.follow_active !== want_word.follow_active) begin
               $error("follow_active: expected %0d, got %0d",
                      want_word.follow_active, got_word.follow_active);
               failures++;
            end
         end
      end
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule
